### design/agq_pkg.sv
// agq_pkg: constants and types shared by the arctangent quadrature block.
// Depends on nothing.
`timescale 1ns / 1ps
package agq_pkg;

   localparam int PAIRS = 7;
   localparam int LANES = 2 * PAIRS;

   // decimal (13 digits) to Q30: round(v * 2^30 / 10^13)
   localparam logic [63:0] Q30_DEN  = 64'd2441406250;
   localparam logic [63:0] Q30_HALF = 64'd1220703125;

   localparam logic [29:0] WEIGHT_Q30 [PAIRS] = '{
      30'(((64'd2152638534632 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd2051984637213 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd1855383974779 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd1572031671582 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd1215185706879 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd801580871598  << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd351194603318  << 18) + Q30_HALF) / Q30_DEN)
   };

   localparam logic [29:0] NODE_Q30 [PAIRS] = '{
      30'(((64'd1080549487073 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd3191123689279 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd5152486363582 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd6872929048117 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd8272013150698 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd9284348836636 << 18) + Q30_HALF) / Q30_DEN),
      30'(((64'd9862838086968 << 18) + Q30_HALF) / Q30_DEN)
   };

   localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

   // sideband that rides along with the reciprocal divider
   typedef struct packed {
      logic        neg;
      logic        zero;
      logic        big;
      logic [16:0] mag_lo;
   } front_type;

   // sideband for the quadrature part; t is unsigned Q32 in [0, 2^32]
   typedef struct packed {
      logic        neg;
      logic        zero;
      logic        big;
      logic [32:0] t;
   } meta_type;

endpackage

### design/agq_req_if.sv
// agq_req_if: argument channel, valid/ready with a signed Q16.16 payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface agq_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

### design/agq_rsp_if.sv
// agq_rsp_if: result channel, valid/ready with a signed Q1.30 angle.
// Depends on nothing.
`timescale 1ns / 1ps
interface agq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

### design/agq_div_pipe.sv
// agq_div_pipe: pipelined restoring divider, one quotient bit per stage.
// Needs num >> QUOT_W < den. Depends on nothing.
`timescale 1ns / 1ps
module agq_div_pipe #(
   parameter int NUM_W  = 49,
   parameter int DEN_W  = 32,
   parameter int QUOT_W = 32
) (
   input  logic              clock,
   input  logic              advance,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic [QUOT_W-1:0] quot
);

   logic [DEN_W-1:0]  rem_ff  [QUOT_W];
   logic [DEN_W-1:0]  den_ff  [QUOT_W];
   logic [QUOT_W-1:0] low_ff  [QUOT_W];
   logic [QUOT_W-1:0] quot_ff [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic [DEN_W-1:0]  rem_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [QUOT_W-1:0] low_prev;
      logic [QUOT_W-1:0] quot_prev;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev  = DEN_W'(num[NUM_W-1:QUOT_W]);
         assign den_prev  = den;
         assign low_prev  = num[QUOT_W-1:0];
         assign quot_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign quot_prev = quot_ff[k-1];
      end

      assign trial = {rem_prev, low_prev[QUOT_W-1]};
      assign diff  = trial - {1'b0, den_prev};
      assign ge    = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            den_ff[k]  <= den_prev;
            low_ff[k]  <= low_prev << 1;
            quot_ff[k] <= {quot_prev[QUOT_W-2:0], ge};
         end
      end
   end

   assign quot = quot_ff[QUOT_W-1];

endmodule

### design/arctangent_gauss_quadrature.sv
// Arctangent by 14-node Gauss-Legendre quadrature, Q16.16 in, Q1.30 out.
// One beat per cycle while the output register is not stalled.
// Latency is set by two pipelined dividers (32 and 31 stages) plus lanes.
// Stalls freeze the whole pipeline; ready drops only while a result waits.
// Reset (synchronous) clears the valid bits; data registers are not reset.
`timescale 1ns / 1ps
module arctangent_gauss_quadrature
   import agq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   agq_req_if.sink   req_bus,
   agq_rsp_if.source rsp_bus
);

   // reciprocal divider: round(2^48 / mag)
   localparam int T_NW = 49;
   localparam int T_DW = 32;
   localparam int T_QW = 32;
   // lane divider: round(2^62 / d)
   localparam int Q_NW = 63;
   localparam int Q_DW = 33;
   localparam int Q_QW = 31;
   // sideband line: three lane stages then the lane divider
   localparam int LINE_B = 3 + Q_QW;
   localparam int M_STAGES = 6;

   logic        adv;
   logic        accept;
   logic        rsp_valid_ff;
   logic [31:0] angle_ff;

   // whole pipeline moves unless a result is stuck in the output register
   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign accept        = req_bus.valid && adv;

   // ---------------- front: sign, magnitude, range split ----------------
   logic [31:0]     raw;
   logic [31:0]     mag;
   front_type       front;
   logic [T_NW-1:0] t_num;
   logic [T_QW-1:0] t_quot;

   assign raw = req_bus.x_value;
   assign mag = raw[31] ? (~raw + 32'd1) : raw;

   always_comb begin
      front.neg    = raw[31];
      front.zero   = (mag == 32'd0);
      front.big    = (mag > 32'd65536);
      front.mag_lo = mag[16:0];
   end

   // 2^48 + mag/2, so the quotient comes out rounded
   assign t_num = {1'b1, 17'b0, mag[31:1]};

   agq_div_pipe #(.NUM_W(T_NW), .DEN_W(T_DW), .QUOT_W(T_QW)) u_tdiv (
      .clock   (clock),
      .advance (adv),
      .num     (t_num),
      .den     (mag),
      .quot    (t_quot)
   );

   front_type       a_meta_ff [T_QW];
   logic [T_QW-1:0] a_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= '0;
      end else if (adv) begin
         a_vld_ff <= {a_vld_ff[T_QW-2:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_meta_ff[0] <= front;
         for (int k = 1; k < T_QW; k++) begin
            a_meta_ff[k] <= a_meta_ff[k-1];
         end
      end
   end

   // ---------------- P1: reduced magnitude t ----------------
   meta_type p1_ff;
   logic     p1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= a_vld_ff[T_QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff.neg  <= a_meta_ff[T_QW-1].neg;
         p1_ff.zero <= a_meta_ff[T_QW-1].zero;
         p1_ff.big  <= a_meta_ff[T_QW-1].big;
         p1_ff.t    <= a_meta_ff[T_QW-1].big ? {1'b0, t_quot}
                                              : {a_meta_ff[T_QW-1].mag_lo, 16'b0};
      end
   end

   // ---------------- sideband line across the lanes ----------------
   meta_type          b_meta_ff [LINE_B];
   logic [LINE_B-1:0] b_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= '0;
      end else if (adv) begin
         b_vld_ff <= {b_vld_ff[LINE_B-2:0], p1_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_meta_ff[0] <= p1_ff;
         for (int k = 1; k < LINE_B; k++) begin
            b_meta_ff[k] <= b_meta_ff[k-1];
         end
      end
   end

   // ---------------- 14 lanes: node, square, reciprocal ----------------
   logic [Q_QW-1:0] q_lane [LANES];

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      localparam int PAIR = i / 2;
      // even lanes take (1 - x), odd lanes (1 + x), in Q30
      localparam logic [31:0] FACTOR = (i % 2 == 1) ? (ONE_Q30 + 32'(NODE_Q30[PAIR]))
                                                    : (ONE_Q30 - 32'(NODE_Q30[PAIR]));
      logic [63:0]     prod_ff;
      logic [31:0]     u_ff;
      logic [63:0]     uu_ff;
      logic [64:0]     u_sum;
      logic [64:0]     u2_sum;
      logic [Q_DW-1:0] den;
      logic [Q_NW-1:0] num;

      // u = round(t * factor / 2^31); the t = 2^32 case is added as a shift
      assign u_sum = {1'b0, prod_ff}
                   + (b_meta_ff[0].t[32] ? {1'b0, FACTOR, 32'b0} : 65'd0)
                   + 65'h0_4000_0000;
      assign u2_sum = {1'b0, uu_ff} + 65'h0_8000_0000;
      assign den    = {1'b1, u2_sum[63:32]};
      assign num    = {1'b1, 30'b0, den[Q_DW-1:1]};

      always_ff @(posedge clock) begin
         if (adv) begin
            prod_ff <= 64'(p1_ff.t[31:0]) * 64'(FACTOR);
            u_ff    <= u_sum[62:31];
            uu_ff   <= 64'(u_ff) * 64'(u_ff);
         end
      end

      agq_div_pipe #(.NUM_W(Q_NW), .DEN_W(Q_DW), .QUOT_W(Q_QW)) u_qdiv (
         .clock   (clock),
         .advance (adv),
         .num     (num),
         .den     (den),
         .quot    (q_lane[i])
      );
   end

   // ---------------- weighted sum and final scaling ----------------
   meta_type            m_meta_ff [M_STAGES];
   logic [M_STAGES-1:0] m_vld_ff;
   logic [61:0]         m1_ff [PAIRS];
   logic [62:0]         s2_ff [4];
   logic [63:0]         s3_ff [2];
   logic [63:0]         s4_ff;
   logic [63:0]         s_round;
   logic [31:0]         s30_ff;
   logic [63:0]         p5_ff;
   logic [64:0]         p_sum;
   logic [30:0]         partial_ff;
   logic [30:0]         ang_mag;
   logic [31:0]         ang_signed;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= '0;
      end else if (adv) begin
         m_vld_ff <= {m_vld_ff[M_STAGES-2:0], b_vld_ff[LINE_B-1]};
      end
   end

   assign s_round = s4_ff + 64'h2000_0000;
   assign p_sum   = {1'b0, p5_ff}
                  + (m_meta_ff[4].t[32] ? {1'b0, s30_ff, 32'b0} : 65'd0)
                  + 65'h1_0000_0000;

   always_ff @(posedge clock) begin
      if (adv) begin
         m_meta_ff[0] <= b_meta_ff[LINE_B-1];
         for (int k = 1; k < M_STAGES; k++) begin
            m_meta_ff[k] <= m_meta_ff[k-1];
         end
         // M1: w * (q(1-x) + q(1+x))
         for (int p = 0; p < PAIRS; p++) begin
            m1_ff[p] <= 62'(64'(WEIGHT_Q30[p])
                            * 64'({1'b0, q_lane[2*p]} + {1'b0, q_lane[2*p+1]}));
         end
         // M2..M4: adder tree
         s2_ff[0] <= {1'b0, m1_ff[0]} + {1'b0, m1_ff[1]};
         s2_ff[1] <= {1'b0, m1_ff[2]} + {1'b0, m1_ff[3]};
         s2_ff[2] <= {1'b0, m1_ff[4]} + {1'b0, m1_ff[5]};
         s2_ff[3] <= {1'b0, m1_ff[6]};
         s3_ff[0] <= {1'b0, s2_ff[0]} + {1'b0, s2_ff[1]};
         s3_ff[1] <= {1'b0, s2_ff[2]} + {1'b0, s2_ff[3]};
         s4_ff    <= s3_ff[0] + s3_ff[1];
         // M5: S rounded to Q30, times t
         s30_ff   <= s_round[61:30];
         p5_ff    <= 64'(s_round[61:30]) * 64'(m_meta_ff[3].t[31:0]);
         // M6: partial = round(S * t / 2^33)
         partial_ff <= p_sum[63:33];
      end
   end

   // reflect for |x| > 1, then restore the sign
   assign ang_mag    = m_meta_ff[5].big ? (HALF_PI_Q30 - partial_ff) : partial_ff;
   assign ang_signed = m_meta_ff[5].neg ? (~{1'b0, ang_mag} + 32'd1) : {1'b0, ang_mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_vld_ff[M_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff <= m_meta_ff[5].zero ? 32'd0 : ang_signed;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.angle = angle_ff;

   // ---------------- assertions ----------------
   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($signed(angle_ff) <= $signed({1'b0, HALF_PI_Q30})
                     && $signed(angle_ff) >= -$signed({1'b0, HALF_PI_Q30})))
      else $error("angle out of range");

   a_recip_below_one : assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff && p1_ff.big) |-> !p1_ff.t[32])
      else $error("reciprocal of a large magnitude reached one");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(m_vld_ff) && $stable(b_vld_ff) && $stable(a_vld_ff)))
      else $error("pipeline moved during a stall");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_bus.ready)
      else $error("input blocked with an empty output register");

endmodule

### verif/agq_checker.sv
// agq_checker: watches the argument and angle channels, predicts each angle
// and compares. Depends on agq_req_if and agq_rsp_if.
`timescale 1ns / 1ps
module agq_checker (
   input  logic  clock,
   input  logic  reset,
   agq_req_if    req_mon,
   agq_rsp_if    rsp_mon,
   output int    fail_count,
   output int    angles_pending
);

   typedef longint unsigned u64_type;

   u64_type     weight_tab [7];
   u64_type     node_tab [7];
   logic [31:0] angle_queue [$];

   // 13-digit decimal fraction to unsigned Q2.30, rounded
   function automatic u64_type dec_to_q30(input u64_type v);
      return ((v << 18) + 64'd1220703125) / 64'd2441406250;
   endfunction

   initial begin
      weight_tab = '{dec_to_q30(64'd2152638534632), dec_to_q30(64'd2051984637213),
                     dec_to_q30(64'd1855383974779), dec_to_q30(64'd1572031671582),
                     dec_to_q30(64'd1215185706879), dec_to_q30(64'd801580871598),
                     dec_to_q30(64'd351194603318)};
      node_tab   = '{dec_to_q30(64'd1080549487073), dec_to_q30(64'd3191123689279),
                     dec_to_q30(64'd5152486363582), dec_to_q30(64'd6872929048117),
                     dec_to_q30(64'd8272013150698), dec_to_q30(64'd9284348836636),
                     dec_to_q30(64'd9862838086968)};
   end

   // Q30 of 1/(1+u^2), u = (t/2)*factor
   function automatic u64_type inv_one_plus_sq(input u64_type t, input u64_type factor);
      u64_type u, u2, d;
      u  = (t * factor + (64'd1 << 30)) >> 31;
      u2 = (u * u + (64'd1 << 31)) >> 32;
      d  = (64'd1 << 32) + u2;
      return ((64'd1 << 62) + (d >> 1)) / d;
   endfunction

   // integral of 1/(1+u^2) over [0,t], t in Q32, result Q30
   function automatic u64_type quad_integral(input u64_type t);
      u64_type sum, s30;
      sum = 0;
      for (int i = 0; i < 7; i++)
         sum += weight_tab[i] * (inv_one_plus_sq(t, (64'd1 << 30) - node_tab[i])
                               + inv_one_plus_sq(t, (64'd1 << 30) + node_tab[i]));
      s30 = (sum + (64'd1 << 29)) >> 30;
      return (s30 * t + (64'd1 << 32)) >> 33;
   endfunction

   function automatic logic [31:0] arctan_q30(input logic [31:0] x);
      u64_type mag, ang;
      mag = x[31] ? ((64'd1 << 32) - u64_type'(x)) : u64_type'(x);
      if (mag == 0) return 32'd0;
      if (mag > 64'd65536)
         ang = 64'd1686629713 - quad_integral(((64'd1 << 48) + (mag >> 1)) / mag);
      else
         ang = quad_integral(mag << 16);
      if (x[31]) ang = ~ang + 64'd1;
      return ang[31:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            angle_queue.push_back(arctan_q30(req_mon.x_value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (angle_queue.size() == 0)
               report_mismatch($sformatf("angle beat %0h with none expected",
                                         rsp_mon.angle));
            else begin
               logic [31:0] want;
               want = angle_queue.pop_front();
               if (rsp_mon.angle !== want)
                  report_mismatch($sformatf("angle %0h, expected %0h",
                                            rsp_mon.angle, want));
            end
         end
      end
      angles_pending = angle_queue.size();
   end

endmodule

### verif/testbench.sv
// testbench: drives arguments into arctangent_gauss_quadrature and gives the
// verdict. Depends on arctangent_gauss_quadrature, agq_req_if, agq_rsp_if and agq_checker.
`timescale 1ns / 1ps
module testbench;

   logic clock;
   logic reset;
   int   fail_count;
   int   angles_pending;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   hold_rsp;      // request for a long receiver hold-off
   int   quiet_cycles;

   agq_req_if req_bus ();
   agq_rsp_if rsp_bus ();

   arctangent_gauss_quadrature DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   agq_checker angle_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .angles_pending (angles_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one argument beat; random gaps before it, held until taken
   task automatic send_arg(input logic [31:0] x);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.x_value = x;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // random argument: full range, inside |x| <= 1, or close to one
   function automatic logic [31:0] pick_arg();
      logic [31:0] x;
      case ($urandom_range(0, 3))
         0, 1: x = $urandom;
         2: x = $urandom_range(0, 32'h0001_0000);
         default: x = $urandom_range(32'h0000_F000, 32'h0001_1000);
      endcase
      if ($urandom_range(0, 1) && x != 0) x = -x;
      return x;
   endfunction

   task automatic random_args(input int count);
      repeat (count) send_arg(pick_arg());
   endtask

   // receiver: random stalls, plus a long counted hold-off on request
   initial begin
      int held;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready = 1'b0;
            for (held = 1; held < 300; held++) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_bus.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: too long with no beat on either channel ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 3000) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] directed [$];
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.x_value = '0;
      hold_rsp        = 1'b0;
      send_idle_pct   = 13;
      recv_idle_pct   = 51;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // zero, unit magnitude both sides of one, extremes, most negative
      directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0000,
                   32'h0001_0001, 32'hFFFF_0000, 32'hFFFE_FFFF, 32'hFFFF_0001,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h0000_8000,
                   32'h0002_0000, 32'h4000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_0002, 32'h0001_8000, 32'hC000_0000};
      foreach (directed[i]) send_arg(directed[i]);

      random_args(460);

      // sender pauses until the pipe has drained
      wait (angles_pending == 0);
      send_idle_pct = 51;
      recv_idle_pct = 13;
      random_args(480);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver hold-off while beats keep coming: pipe fills, input stalls
      hold_rsp = 1'b1;
      random_args(160);
      random_args(330);

      wait (angles_pending == 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
